// ===== hdl/rrgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrgd_pkg
// Types and constants shared by the ridge regression solver.
// ----------------------------------------------------------------------------
package rrgd_pkg;
	localparam int IN_FEATURES = 4;
	localparam int ACC_W = 48;
	localparam int W_W = 32;
	localparam logic signed [W_W-1:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [1:0] REG_STEP = 2'd0;
	localparam logic [1:0] REG_RIDGE = 2'd1;
	localparam logic [1:0] REG_ITER = 2'd2;
	localparam logic [1:0] REG_ACTIVE = 2'd3;

	typedef struct packed {
		logic signed [15:0] feature_0;
		logic signed [15:0] feature_1;
		logic signed [15:0] feature_2;
		logic signed [15:0] feature_3;
		logic signed [15:0] target_value;
		logic               final_sample;
	} sample_t;

	typedef struct packed {
		logic [1:0]         weight_index;
		logic signed [31:0] weight_value;
		logic               last_weight;
	} weight_t;

	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W+1:0] x);
		if (x > $signed({2'b00, ACC_MAX})) return ACC_MAX;
		if (x < $signed({2'b11, ACC_MIN})) return ACC_MIN;
		return x[ACC_W-1:0];
	endfunction

	// floor((x + 2^15) / 2^16)
	function automatic logic signed [79:0] shr16_round(input logic signed [79:0] x);
		logic signed [79:0] y;
		y = x + 80'sd32768;
		return y >>> 16;
	endfunction
endpackage

// ===== hdl/rrgd_ram.sv =====
// ----------------------------------------------------------------------------
// rrgd_ram
// Generic single-port-write, one-read RAM with registered read.
// ----------------------------------------------------------------------------
module rrgd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/rrgd_divider.sv =====
// ----------------------------------------------------------------------------
// rrgd_divider
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
// ----------------------------------------------------------------------------
module rrgd_divider
	import rrgd_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [ACC_W-1:0]       dividend,
	input  logic [COUNT_BITS-1:0]         divisor,
	output logic                          done,
	output logic signed [ACC_W-1:0]       quotient
);
	localparam int NB = ACC_W + 1;
	logic              busy_q, neg_q;
	logic [NB-1:0]     num_q, quo_q;
	logic [COUNT_BITS:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [$clog2(NB+1)-1:0] cnt_q;
	logic [COUNT_BITS+1:0] trial;
	logic [NB-1:0]     mag;

	assign mag = dividend[ACC_W-1] ? NB'(-$signed({dividend[ACC_W-1], dividend}))
		: NB'({1'b0, dividend});
	assign trial = {rem_q, num_q[NB-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(NB+1))'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(NB+1))'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			num_q <= mag + NB'(divisor >> 1);
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!trial[COUNT_BITS+1]) begin
				rem_q <= trial[COUNT_BITS:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[COUNT_BITS-1:0], num_q[NB-1]};
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? ACC_W'(-$signed(quo_q)) : ACC_W'(quo_q);
endmodule

// ===== hdl/ridge_regression_gd_solver.sv =====
// ----------------------------------------------------------------------------
// ridge_regression_gd_solver
// Accumulates sample moments and solves ridge regression by gradient descent.
// ----------------------------------------------------------------------------
// Each accepted request is one sample. Accumulation reads, updates and writes
// back covariance and cross entries held in one RAM, one entry per read and
// write state pair, through a single 16x16 multiplier. The RAM uses NENT =
// F*S+F entries, where S is the power of two at or above F (two for one
// feature), and a sample keeps the input stalled until every entry is
// updated. A request marked final_sample then starts the solve: each used
// moment is divided by the sample count with a bit-serial divider (skipped
// entries are passed over without a division), weights start at 1.0, and
// every iteration walks the mean matrix from a second RAM, one product per
// MAC and SUM state pair. After the solve one weight request per active
// feature is sent, and the moment RAM is cleared, one entry at a time, while
// no sample is accepted (also right after reset). Configuration writes are
// taken at any time and should be made while idle.
module ridge_regression_gd_solver
	import rrgd_pkg::*;
#(
	parameter int FEATURES = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  sample_t       in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output weight_t       out_data
);
	localparam int LANES = (FEATURES < IN_FEATURES) ? FEATURES : IN_FEATURES;
	localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int STRIDE = 1 << FW;
	localparam int NENT = FEATURES * STRIDE + FEATURES;
	localparam int AW = $clog2(NENT + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_ACC_RD = 4'd1, ST_ACC_WR = 4'd2,
		ST_DIV_RD = 4'd3, ST_DIV_GO = 4'd4, ST_DIV_WT = 4'd5, ST_IT_RD = 4'd6,
		ST_IT_MAC = 4'd7, ST_IT_UPD = 4'd8, ST_IT_STEP = 4'd9, ST_EMIT = 4'd10,
		ST_CLEAR = 4'd11, ST_IT_NEXT = 4'd12, ST_IT_SUM = 4'd13;

	logic [3:0] state_q;
	logic [15:0] step_q, ridge_q, iter_q;
	logic [2:0] active_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [15:0] x_q [IN_FEATURES];
	logic signed [15:0] y_q;
	logic final_q;
	logic [AW-1:0] ent_q;
	logic [15:0] itc_q;
	logic [FW-1:0] row_q, col_q;
	logic [FW:0] k_q;
	logic signed [W_W-1:0] th_q [FEATURES];
	logic signed [W_W-1:0] nx_q [FEATURES];
	logic signed [79:0] acc_q;
	logic signed [ACC_W-1:0] cbar_q, grad_q;
	logic mac_v_s1;

	// moment RAM: covariance rows of STRIDE entries, then cross entries
	logic mom_we;
	logic [AW-1:0] mom_wa, mom_ra;
	logic [ACC_W-1:0] mom_wd, mom_rd;
	rrgd_ram #(.WIDTH(ACC_W), .DEPTH(2**AW)) u_mom (
		.clk(clk), .we(mom_we), .waddr(mom_wa), .wdata(mom_wd),
		.raddr(mom_ra), .rdata(mom_rd));

	// mean RAM: same layout
	logic mean_we;
	logic [AW-1:0] mean_ra;
	logic [ACC_W-1:0] mean_rd;
	logic div_done;
	logic signed [ACC_W-1:0] div_q;
	rrgd_ram #(.WIDTH(ACC_W), .DEPTH(2**AW)) u_mean (
		.clk(clk), .we(mean_we), .waddr(ent_q), .wdata(div_q),
		.raddr(mean_ra), .rdata(mean_rd));

	rrgd_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV_GO),
		.dividend(mom_rd), .divisor((count_q == '0) ? COUNT_BITS'(1) : count_q),
		.done(div_done), .quotient(div_q));

	// entry decode for accumulation
	logic [FW-1:0] ei, ej;
	logic is_cross, ent_used;
	always_comb begin
		is_cross = ent_q >= AW'(FEATURES * STRIDE);
		if (is_cross) begin
			ei = FW'(ent_q - AW'(FEATURES * STRIDE));
			ej = '0;
		end else begin
			ei = FW'(ent_q >> FW);
			ej = ent_q[FW-1:0];
		end
		ent_used = (32'(ei) < LANES) && (is_cross || 32'(ej) < LANES);
	end

	logic signed [15:0] xa, xb;
	logic signed [31:0] prod_s1;
	always_comb begin
		xa = x_q[ei[$clog2(IN_FEATURES)-1:0]];
		xb = is_cross ? y_q : x_q[ej[$clog2(IN_FEATURES)-1:0]];
	end

	assign mom_we = (state_q == ST_ACC_WR && ent_used) || state_q == ST_CLEAR;
	assign mom_wa = ent_q;
	assign mom_wd = (state_q == ST_CLEAR) ? '0
		: sat48(50'(signed'(mom_rd)) + 50'(prod_s1));
	assign mom_ra = ent_q;

	// the sum cycle already fetches the next column
	logic [AW-1:0] mean_idx;
	assign mean_idx = (state_q == ST_IT_STEP || state_q == ST_IT_UPD)
		? AW'(FEATURES * STRIDE) + AW'(row_q)
		: AW'(row_q) * AW'(STRIDE) + AW'(col_q) + AW'(state_q == ST_IT_SUM);
	assign mean_ra = mean_idx;
	assign mean_we = div_done;

	// which divided entries matter: row/col below k
	logic div_used;
	always_comb begin
		if (is_cross) div_used = 32'(ei) < 32'(k_q);
		else div_used = (32'(ei) < 32'(k_q)) && (32'(ej) < 32'(k_q));
	end

	// solve datapath: mean*theta products through their own multiplier
	logic signed [79:0] mprod_s1;
	logic signed [79:0] ridge_term, step_full;
	logic signed [ACC_W-1:0] g_sat;
	logic signed [63:0] th_ext;
	assign ridge_term = shr16_round(80'(signed'({1'b0, ridge_q})) * 80'(th_q[row_q]));
	assign g_sat = sat48(50'(acc_q - 80'(cbar_q) + ridge_term));
	assign step_full = shr16_round(80'(signed'({1'b0, step_q})) * 80'(grad_q));
	always_comb begin
		if (80'(th_q[row_q]) - step_full > 80'sd2147483647) th_ext = 64'sd2147483647;
		else if (80'(th_q[row_q]) - step_full < -80'sd2147483648) th_ext = -64'sd2147483648;
		else th_ext = 64'(80'(th_q[row_q]) - step_full);
	end

	logic [2:0] kc;
	always_comb begin
		kc = active_q;
		if (kc == 3'd0) kc = 3'd1;
		if (32'(kc) > LANES) kc = 3'(LANES);
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_EMIT;
	assign out_data.weight_index = 2'(row_q);
	assign out_data.weight_value = th_q[row_q];
	assign out_data.last_weight = (FW + 1)'(row_q) + 1'b1 == k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 16'd655;
			ridge_q <= '0;
			iter_q <= 16'd1000;
			active_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP: step_q <= cfg_data;
				REG_RIDGE: ridge_q <= cfg_data;
				REG_ITER: iter_q <= cfg_data;
				REG_ACTIVE: active_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// a mean is a sum of n products of 16-bit values over n, so it stays
	// within 2^30 and its low word carries it whole
	always_ff @(posedge clk) begin
		prod_s1 <= xa * xb;
		mprod_s1 <= 80'(signed'(mean_rd[31:0])) * 80'(th_q[col_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ent_q <= '0;
			count_q <= '0;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			itc_q <= '0;
			mac_v_s1 <= 1'b0;
			for (int i = 0; i < FEATURES; i++) th_q[i] <= ONE_Q16;
		end else begin
			mac_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q[0] <= in_data.feature_0;
						x_q[1] <= in_data.feature_1;
						x_q[2] <= in_data.feature_2;
						x_q[3] <= in_data.feature_3;
						y_q <= in_data.target_value;
						final_q <= in_data.final_sample;
						k_q <= (FW + 1)'(kc);
						ent_q <= '0;
						state_q <= (count_q < COUNT_MAX) ? ST_ACC_RD : ST_DIV_RD;
						if (count_q < COUNT_MAX) count_q <= count_q + 1'b1;
						else if (!in_data.final_sample) state_q <= ST_IDLE;
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: begin
					if (ent_q == AW'(NENT - 1)) begin
						ent_q <= '0;
						state_q <= final_q ? ST_DIV_RD : ST_IDLE;
					end else begin
						ent_q <= ent_q + 1'b1;
						state_q <= ST_ACC_RD;
					end
				end
				ST_DIV_RD: begin
					if (ent_q == AW'(NENT)) begin
						for (int i = 0; i < FEATURES; i++) th_q[i] <= ONE_Q16;
						row_q <= '0;
						col_q <= '0;
						itc_q <= '0;
						state_q <= (iter_q == '0) ? ST_EMIT : ST_IT_RD;
					end else if (!div_used) ent_q <= ent_q + 1'b1;
					else state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WT;
				ST_DIV_WT: if (div_done) begin
					ent_q <= ent_q + 1'b1;
					state_q <= ST_DIV_RD;
				end
				ST_IT_RD: begin
					col_q <= '0;
					acc_q <= '0;
					state_q <= ST_IT_MAC;
					mac_v_s1 <= 1'b0;
				end
				ST_IT_MAC: begin
					// mean_rd holds [row][col]; product lands next cycle
					mac_v_s1 <= 1'b1;
					state_q <= ST_IT_SUM;
				end
				ST_IT_SUM: begin
					acc_q <= acc_q + shr16_round(mprod_s1);
					if ((FW + 1)'(col_q) + 1'b1 == k_q) state_q <= ST_IT_UPD;
					else begin
						col_q <= col_q + 1'b1;
						state_q <= ST_IT_MAC;
					end
				end
				ST_IT_UPD: state_q <= ST_IT_NEXT;
				ST_IT_NEXT: begin
					cbar_q <= mean_rd;
					state_q <= ST_IT_STEP;
					col_q <= '0;
				end
				ST_IT_STEP: begin
					if (grad_q == g_sat && mac_v_s1) begin
						nx_q[row_q] <= 32'(th_ext);
						if ((FW + 1)'(row_q) + 1'b1 == k_q) begin
							for (int i = 0; i < FEATURES; i++)
								if (32'(i) < 32'(k_q)) th_q[i] <= (i == int'(row_q))
									? 32'(th_ext) : nx_q[i];
							row_q <= '0;
							itc_q <= itc_q + 1'b1;
							state_q <= (itc_q + 1'b1 == iter_q) ? ST_EMIT : ST_IT_RD;
						end else begin
							row_q <= row_q + 1'b1;
							state_q <= ST_IT_RD;
						end
					end else begin
						mac_v_s1 <= 1'b1;
					end
				end
				ST_EMIT: if (!out_stall) begin
					if ((FW + 1)'(row_q) + 1'b1 == k_q) begin
						row_q <= '0;
						ent_q <= '0;
						count_q <= '0;
						state_q <= ST_CLEAR;
					end else row_q <= row_q + 1'b1;
				end
				ST_CLEAR: begin
					if (ent_q == AW'(NENT - 1)) begin
						ent_q <= '0;
						state_q <= ST_IDLE;
						for (int i = 0; i < FEATURES; i++) th_q[i] <= ONE_Q16;
					end else ent_q <= ent_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// gradient register: g_sat is computed in the cycle after cbar is loaded
	always_ff @(posedge clk) begin
		grad_q <= g_sat;
	end

	// no request is taken during weight output, the clearing pass follows the last weight, and nothing is output during it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("sample accepted during weight output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_weight) |=> state_q == ST_CLEAR)
		else $error("moments not cleared after last weight");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid)
		else $error("output during clearing pass");
endmodule

// ===== sim/rrgd_checker.sv =====
// ----------------------------------------------------------------------------
// rrgd_checker
// Watches the sample, weight and register ports of the solver, predicts the
// fitted weights of every solve and compares them in order.
// ----------------------------------------------------------------------------
module rrgd_checker
	import rrgd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic    in_valid,
	input  logic    in_stall,
	input  sample_t in_data,
	input  logic    out_valid,
	input  logic    out_stall,
	input  weight_t out_data,
	output int      errors,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES = 4;
	localparam int COUNT_MAX = 65535;

	logic signed [47:0] cov_sum [LANES][LANES];
	logic signed [47:0] cross_sum [LANES];
	logic signed [31:0] theta [LANES];
	int unsigned n_seen;
	logic [15:0] alpha, lambda, n_iter;
	logic [2:0]  n_active;
	weight_t weight_q [$];

	function automatic logic signed [47:0] clip48(input logic signed [79:0] x);
		if (x > 80'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		if (x < -80'sh8000_0000_0000) return 48'sh8000_0000_0000;
		return x[47:0];
	endfunction

	function automatic logic signed [31:0] clip32(input logic signed [79:0] x);
		if (x > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -80'sh8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// Q32.32 -> Q16.16, ties go up
	function automatic logic signed [79:0] q16_round(input logic signed [79:0] x);
		logic signed [79:0] y;
		y = x + 80'sd32768;
		return y >>> 16;
	endfunction

	// mean of a moment, ties away from zero
	function automatic logic signed [79:0] mean_of(input logic signed [47:0] s,
			input int unsigned n);
		logic [79:0] mag;
		mag = (s < 0) ? -{{32{s[47]}}, s} : {32'd0, s};
		mag = (mag + n / 2) / n;
		return (s < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	task automatic fit_weights(input int k);
		logic signed [79:0] m [LANES][LANES];
		logic signed [79:0] cb [LANES];
		logic signed [31:0] nxt [LANES];
		logic signed [79:0] acc, grad, stp;
		int unsigned n;
		n = (n_seen == 0) ? 1 : n_seen;
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < k; j++)
				m[i][j] = mean_of(cov_sum[i][j], n);
			cb[i] = mean_of(cross_sum[i], n);
		end
		for (int i = 0; i < LANES; i++)
			theta[i] = ONE_Q16;
		for (int it = 0; it < n_iter; it++) begin
			for (int i = 0; i < k; i++) begin
				acc = 0;
				for (int j = 0; j < k; j++)
					acc += q16_round(m[i][j] * 80'(theta[j]));
				grad = acc - cb[i] + q16_round($signed({64'd0, lambda}) * 80'(theta[i]));
				grad = 80'(clip48(grad));
				stp = q16_round($signed({64'd0, alpha}) * grad);
				nxt[i] = clip32(80'(theta[i]) - stp);
			end
			for (int i = 0; i < k; i++)
				theta[i] = nxt[i];
		end
	endtask

	task automatic take_sample(input sample_t s);
		logic signed [15:0] x [LANES];
		weight_t w;
		int k;
		x[0] = s.feature_0; x[1] = s.feature_1;
		x[2] = s.feature_2; x[3] = s.feature_3;
		// a full count drops the sample but a final mark still solves
		if (n_seen < COUNT_MAX) begin
			for (int i = 0; i < LANES; i++) begin
				for (int j = 0; j < LANES; j++)
					cov_sum[i][j] = clip48(80'(cov_sum[i][j]) + 80'(x[i] * x[j]));
				cross_sum[i] = clip48(80'(cross_sum[i]) + 80'(x[i] * s.target_value));
			end
			n_seen++;
		end
		if (!s.final_sample) return;
		k = (n_active < 1) ? 1 : (n_active > LANES) ? LANES : n_active;
		fit_weights(k);
		for (int i = 0; i < k; i++) begin
			w.weight_index = i[1:0];
			w.weight_value = theta[i];
			w.last_weight = (i + 1 == k);
			weight_q.push_back(w);
		end
		for (int i = 0; i < LANES; i++) begin
			for (int j = 0; j < LANES; j++)
				cov_sum[i][j] = '0;
			cross_sum[i] = '0;
		end
		n_seen = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		weight_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				for (int j = 0; j < LANES; j++)
					cov_sum[i][j] = '0;
				cross_sum[i] = '0;
				theta[i] = ONE_Q16;
			end
			n_seen = 0;
			alpha = 16'd655;
			lambda = 16'd0;
			n_iter = 16'd1000;
			n_active = 3'd4;
			errors = 0;
			weight_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP:   alpha = cfg_data;
					REG_RIDGE:  lambda = cfg_data;
					REG_ITER:   n_iter = cfg_data;
					REG_ACTIVE: n_active = cfg_data[2:0];
				endcase
			end
			if (out_valid && !out_stall) begin
				if (weight_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected weight request %p", $realtime, out_data);
				end else begin
					exp_w = weight_q.pop_front();
					if (out_data !== exp_w) begin
						errors++;
						if (errors <= 10)
							$display("%0t: weight mismatch exp %p got %p",
								$realtime, exp_w, out_data);
					end
				end
			end
			if (in_valid && !in_stall)
				take_sample(in_data);
		end
		pending = weight_q.size();
	end

	final begin
	end
endmodule

// ===== sim/ridge_regression_gd_solver_tb.sv =====
// ----------------------------------------------------------------------------
// ridge_regression_gd_solver_tb
// Feeds training samples and register settings to the solver with random
// gaps on both channels; a checker beside the block predicts every weight.
// ----------------------------------------------------------------------------
module ridge_regression_gd_solver_tb;
	import rrgd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 80;     // sample accumulate plus moment RAM clear

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic    in_valid;
	logic    in_stall;
	sample_t in_data;
	logic    out_valid;
	logic    out_stall;
	weight_t out_data;
	int      errors;
	int      pending;
	int      cycles;
	int      sent;
	bit      calm;              // no idling on either side while set

	ridge_regression_gd_solver i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	rrgd_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ridge_regression_gd_solver_tb: FAIL");
			$finish;
		end
	end

	// weight side: after each taken request hold stall for a random count
	initial begin
		int hold;
		bit took;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			took = out_valid && !out_stall;
			@(posedge clk);
			if (took)
				hold = calm ? 0 : $urandom_range(0, 16);
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	// one request on the sample channel; returns at the edge that took it
	task automatic send(input sample_t s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sent++;
	endtask

	function automatic sample_t pick(input bit fin);
		sample_t s;
		bit wide;
		wide = ($urandom_range(0, 3) == 0);
		s = '0;
		s.feature_0 = wide ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
		s.feature_1 = wide ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
		s.feature_2 = wide ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
		s.feature_3 = wide ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
		s.target_value = wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
		s.final_sample = fin;
		return s;
	endfunction

	function automatic sample_t flat(input logic [15:0] v, input bit fin);
		return '{v, v, v, v, v, fin};
	endfunction

	// registers change only with the block idle: all weights in, RAM cleared
	task automatic set_regs(input logic [15:0] step, input logic [15:0] ridge,
			input logic [15:0] iters, input logic [2:0] active);
		in_valid <= 1'b0;
		// sampled between edges so a request taken at this edge is counted
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_STEP;   cfg_data <= step;   @(posedge clk);
		cfg_index <= REG_RIDGE;  cfg_data <= ridge;  @(posedge clk);
		cfg_index <= REG_ITER;   cfg_data <= iters;  @(posedge clk);
		cfg_index <= REG_ACTIVE; cfg_data <= {13'd0, active}; @(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int burst;
		logic [15:0] st, rg;
		cycles = 0;
		sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_STEP;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes of every field, then a solve over all four
		send(flat(16'h7FFF, 1'b0));
		send(flat(16'h8000, 1'b0));
		send(flat(16'h0000, 1'b0));
		send('{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0100, 1'b0});
		send('{16'h0100, 16'h0080, 16'hFF00, 16'h0040, 16'h0200, 1'b1});

		// zero iterations and active count zero: one weight of 1.0
		set_regs(16'd0, 16'd0, 16'd0, 3'd0);
		send(flat(16'h0123, 1'b1));

		// full step and ridge with active count above range: saturation
		set_regs(16'hFFFF, 16'hFFFF, 16'd5, 3'd7);
		send(flat(16'h7FFF, 1'b0));
		send('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1});
		send(flat(16'h8000, 1'b1));

		// longest solve, kept to one column
		set_regs(16'd300, 16'd0, 16'hFFFF, 3'd1);
		send('{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0200, 1'b0});
		send('{16'h0200, 16'h0000, 16'h0000, 16'h0000, 16'h0400, 1'b1});

		// final mark with nothing else accumulated
		set_regs(16'd2000, 16'd100, 16'd20, 3'd2);
		send(pick(1'b1));

		// random phases: new settings, then one to three batches, each ending in a final mark
		while (sent < 170) begin
			st = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));
			rg = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
			set_regs(st, rg, 16'($urandom_range(0, 40)), 3'($urandom_range(0, 7)));
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				burst = $urandom_range(0, 8);
				repeat (burst) send(pick(1'b0));
				send(pick(1'b1));
			end
			calm = 1'b0;
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("ridge_regression_gd_solver_tb: PASS");
		else
			$display("ridge_regression_gd_solver_tb: FAIL");
		$finish;
	end
endmodule
